// ----- rtl/utf8d_pkg.sv -----
// Shared types, constants and lead-byte classification for the UTF-8 decoder.
`timescale 1ns / 1ps

package utf8d_pkg;

  localparam int unsigned CpW     = 21;
  localparam int unsigned MaxRes  = 4;
  localparam int unsigned CntW    = 3;

  localparam logic [7:0] Lead2Lo   = 8'hc2;
  localparam logic [7:0] Lead2Hi   = 8'hdf;
  localparam logic [7:0] Lead3Lo   = 8'he0;
  localparam logic [7:0] Lead3Hi   = 8'hef;
  localparam logic [7:0] Lead4Lo   = 8'hf0;
  localparam logic [7:0] Lead4Hi   = 8'hf4;
  localparam logic [7:0] ContMask  = 8'hc0;
  localparam logic [7:0] ContTag   = 8'h80;
  localparam logic [7:0] E0Min     = 8'ha0;
  localparam logic [7:0] LeadEd    = 8'hed;
  localparam logic [7:0] F0Min     = 8'h90;
  localparam logic [7:0] F4Lim     = 8'h90;
  localparam logic [7:0] EdLim     = 8'ha0;
  localparam logic [7:0] LowMask   = 8'h3f;

  // up to four results produced by one input byte
  typedef struct packed {
    logic [CntW-1:0]           cnt;
    logic [MaxRes-1:0][CpW-1:0] cp;
  } burst_t;

  typedef struct packed {
    logic       emit;  // byte passes through as its own value
    logic [1:0] need;  // continuation bytes a new sequence needs, 0 if none
  } lead_t;

  function automatic lead_t classify_lead(input logic [7:0] b);
    lead_t r;
    r.emit = 1'b0;
    r.need = 2'd0;
    if (b == 8'h00) begin
      r.emit = 1'b0;
    end else if (b >= Lead2Lo && b <= Lead2Hi) begin
      r.need = 2'd1;
    end else if (b >= Lead3Lo && b <= Lead3Hi) begin
      r.need = 2'd2;
    end else if (b >= Lead4Lo && b <= Lead4Hi) begin
      r.need = 2'd3;
    end else begin
      r.emit = 1'b1;
    end
    return r;
  endfunction

  function automatic logic [CpW-1:0] raw_cp(input logic [7:0] b);
    return {{(CpW-8){1'b0}}, b};
  endfunction

endpackage

// ----- rtl/utf8d_decode.sv -----
// Sequence state and per-byte decode into a burst of results.
`timescale 1ns / 1ps

module utf8d_decode (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic [7:0]          byte_i,
  input  logic                advance_i,
  output utf8d_pkg::burst_t   burst_o
);

  logic [7:0] lead_q, lead_d;
  logic [1:0] need_q, need_d;
  logic [1:0] taken_q, taken_d;
  logic [5:0] cont_q [2];
  logic       cont_we;

  utf8d_pkg::lead_t sl;
  logic             ok;
  logic             flush;
  logic [2:0]       nflush;
  logic             extra;
  logic [utf8d_pkg::CpW-1:0] extra_cp;
  logic [utf8d_pkg::CpW-1:0] flush_cp [3];
  logic [5:0]       low;

  assign low = byte_i[5:0];
  assign sl  = utf8d_pkg::classify_lead(byte_i);

  always_comb begin
    ok = ((byte_i & utf8d_pkg::ContMask) == utf8d_pkg::ContTag);
    if (taken_q == 2'd0) begin
      if (lead_q == utf8d_pkg::Lead3Lo && byte_i < utf8d_pkg::E0Min) ok = 1'b0;
      if (lead_q == utf8d_pkg::LeadEd  && byte_i >= utf8d_pkg::EdLim) ok = 1'b0;
      if (lead_q == utf8d_pkg::Lead4Lo && byte_i < utf8d_pkg::F0Min) ok = 1'b0;
      if (lead_q == utf8d_pkg::Lead4Hi && byte_i >= utf8d_pkg::F4Lim) ok = 1'b0;
    end
  end

  assign flush_cp[0] = utf8d_pkg::raw_cp(lead_q);
  assign flush_cp[1] = utf8d_pkg::raw_cp(utf8d_pkg::ContTag | {2'b00, cont_q[0]});
  assign flush_cp[2] = utf8d_pkg::raw_cp(utf8d_pkg::ContTag | {2'b00, cont_q[1]});

  always_comb begin
    lead_d   = lead_q;
    need_d   = need_q;
    taken_d  = taken_q;
    cont_we  = 1'b0;
    flush    = 1'b0;
    extra    = 1'b0;
    extra_cp = utf8d_pkg::raw_cp(byte_i);
    if (need_q == 2'd0 || (byte_i != 8'h00 && !ok)) begin
      // fresh lead, after flushing a broken sequence if one is pending
      flush = (need_q != 2'd0);
      extra = sl.emit;
      lead_d  = (sl.need != 2'd0) ? byte_i : 8'h00;
      need_d  = sl.need;
      taken_d = 2'd0;
    end else if (byte_i == 8'h00) begin
      flush   = 1'b1;
      lead_d  = 8'h00;
      need_d  = 2'd0;
      taken_d = 2'd0;
    end else if ((taken_q + 2'd1) < need_q) begin
      cont_we = 1'b1;
      taken_d = taken_q + 2'd1;
    end else begin
      extra = 1'b1;
      case (need_q)
        2'd1:    extra_cp = {10'b0, lead_q[4:0], low};
        2'd2:    extra_cp = {5'b0, lead_q[3:0], cont_q[0], low};
        default: extra_cp = {lead_q[2:0], cont_q[0], cont_q[1], low};
      endcase
      lead_d  = 8'h00;
      need_d  = 2'd0;
      taken_d = 2'd0;
    end
  end

  assign nflush = flush ? ({1'b0, taken_q} + 3'd1) : 3'd0;

  always_comb begin
    burst_o.cnt = nflush + {2'b00, extra};
    for (int k = 0; k < utf8d_pkg::MaxRes; k++) begin
      if (k < 3 && 3'(k) < nflush) begin
        burst_o.cp[k] = flush_cp[(k < 3) ? k : 0];
      end else begin
        burst_o.cp[k] = extra_cp;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lead_q  <= 8'h00;
      need_q  <= 2'd0;
      taken_q <= 2'd0;
    end else if (advance_i) begin
      lead_q  <= lead_d;
      need_q  <= need_d;
      taken_q <= taken_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance_i && cont_we) begin
      cont_q[taken_q[0]] <= low;
    end
  end

endmodule

// ----- rtl/utf8d_outbuf.sv -----
// Result register holding one burst and presenting it one result per transaction.
`timescale 1ns / 1ps

module utf8d_outbuf (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          load_i,
  input  utf8d_pkg::burst_t             burst_i,
  output logic                          free_o,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [utf8d_pkg::CpW-1:0]     code_point_o,
  output logic                          last_of_run_o
);

  logic [utf8d_pkg::CntW-1:0] rem_q, rem_d;
  logic [utf8d_pkg::MaxRes-1:0][utf8d_pkg::CpW-1:0] cp_q, cp_d;
  logic pop;

  assign out_valid_o   = (rem_q != '0);
  assign pop           = out_valid_o && out_ready_i;
  assign last_of_run_o = (rem_q == utf8d_pkg::CntW'(1));
  assign code_point_o  = cp_q[0];
  // a new burst may enter once the last pending result leaves
  assign free_o        = (rem_q == '0) || (last_of_run_o && out_ready_i);

  always_comb begin
    rem_d = rem_q;
    cp_d  = cp_q;
    if (load_i) begin
      rem_d = burst_i.cnt;
      cp_d  = burst_i.cp;
    end else if (pop) begin
      rem_d = rem_q - utf8d_pkg::CntW'(1);
      for (int k = 0; k < utf8d_pkg::MaxRes - 1; k++) begin
        cp_d[k] = cp_q[k+1];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rem_q <= '0;
    end else begin
      rem_q <= rem_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cp_q <= cp_d;
  end

endmodule

// ----- rtl/utf8_decoder_raw_fallback.sv -----
// Top level: input register, byte decoder and burst output register.
// An accepted byte waits in the input register, is decoded and is loaded into the output
// register once that register is free. Throughput: one byte per cycle while each byte yields
// at most one result and the output takes it; a byte that yields several (a broken sequence,
// up to four) holds input while the single output register drains its burst one result per transaction.
// Reset clears the pending sequence and empties both registers; no clearing pass.
`timescale 1ns / 1ps

module utf8_decoder_raw_fallback (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  output logic                       in_ready_o,
  input  logic [7:0]                 data_byte_i,
  output logic                       out_valid_o,
  input  logic                       out_ready_i,
  output logic [utf8d_pkg::CpW-1:0]  code_point_o,
  output logic                       last_of_run_o
);

  logic       in_vld_q;
  logic [7:0] byte_q;
  logic       free;
  logic       advance;
  utf8d_pkg::burst_t burst;

  assign advance    = in_vld_q && free;
  assign in_ready_o = !in_vld_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (in_ready_o) begin
      in_vld_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      byte_q <= data_byte_i;
    end
  end

  utf8d_decode u_decode (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .byte_i    (byte_q),
    .advance_i (advance),
    .burst_o   (burst)
  );

  utf8d_outbuf u_outbuf (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .load_i        (advance),
    .burst_i       (burst),
    .free_o        (free),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .code_point_o  (code_point_o),
    .last_of_run_o (last_of_run_o)
  );

endmodule

// ----- rtl/utf8d_checker.sv -----
// Port-level checks for the UTF-8 decoder, bound to the top level.
`timescale 1ns / 1ps

module utf8d_checker (
  input logic                       clk_i,
  input logic                       rst_ni,
  input logic                       in_ready_o,
  input logic                       out_valid_o,
  input logic                       out_ready_i,
  input logic [utf8d_pkg::CpW-1:0]  code_point_o,
  input logic                       last_of_run_o
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o)
    else $error("result valid dropped before transaction");

  a_run_continues: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_ready_i && !last_of_run_o |=> out_valid_o)
    else $error("result run ended without last_of_run");

  a_scalar_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> code_point_o <= 21'h10ffff)
    else $error("code point above scalar range");

  a_flush_raw: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !last_of_run_o |-> code_point_o < 21'h100)
    else $error("non-final result is not a raw byte");

  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> out_valid_o)
    else $error("input stalled with no result pending");

endmodule

bind utf8_decoder_raw_fallback utf8d_checker u_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .in_ready_o    (in_ready_o),
  .out_valid_o   (out_valid_o),
  .out_ready_i   (out_ready_i),
  .code_point_o  (code_point_o),
  .last_of_run_o (last_of_run_o)
);

// ----- test/tb_utf8_decoder_raw_fallback.sv -----
// Self-checking testbench for the UTF-8 decoder with raw-byte fallback.
`timescale 1ns / 1ps

module tb_utf8_decoder_raw_fallback;

  // Tracks the decoder state and holds the code points still owed by the DUT.
  class utf8_scoreboard;
    typedef struct packed {
      logic [utf8d_pkg::CpW-1:0] cp;
      logic                      last;
    } cp_item_t;

    logic [7:0]                lead;
    logic [1:0]                need;
    logic [1:0]                taken;
    logic [5:0]                cont[2];
    logic [utf8d_pkg::CpW-1:0] burst_q[$];
    cp_item_t                  owed_q[$];
    int                        errors;
    int                        bytes_seen;
    int                        cps_checked;
    int                        multi_bursts;

    function new();
      lead = '0;
      need = '0;
      taken = '0;
      cont[0] = '0;
      cont[1] = '0;
      errors = 0;
      bytes_seen = 0;
      cps_checked = 0;
      multi_bursts = 0;
    endfunction

    function void clear_seq();
      lead = '0;
      need = '0;
      taken = '0;
    endfunction

    // lead raw, then every continuation already taken
    function void flush_raw();
      burst_q.push_back(utf8d_pkg::CpW'(lead));
      for (int i = 0; i < int'(taken) && i < 2; i++) begin
        burst_q.push_back(utf8d_pkg::CpW'({2'b10, cont[i]}));
      end
      clear_seq();
    endfunction

    function void open_lead(logic [7:0] b);
      if (b == 8'h00) begin
        return;
      end
      if (b < utf8d_pkg::ContTag) begin
        burst_q.push_back(utf8d_pkg::CpW'(b));
      end else if (b >= utf8d_pkg::Lead2Lo && b <= utf8d_pkg::Lead2Hi) begin
        lead = b;
        need = 2'd1;
        taken = 2'd0;
      end else if (b >= utf8d_pkg::Lead3Lo && b <= utf8d_pkg::Lead3Hi) begin
        lead = b;
        need = 2'd2;
        taken = 2'd0;
      end else if (b >= utf8d_pkg::Lead4Lo && b <= utf8d_pkg::Lead4Hi) begin
        lead = b;
        need = 2'd3;
        taken = 2'd0;
      end else begin
        burst_q.push_back(utf8d_pkg::CpW'(b));
      end
    endfunction

    function void note_byte(logic [7:0] b);
      bit                        cont_good;
      logic [utf8d_pkg::CpW-1:0] cp;
      cp_item_t                  item;
      bytes_seen++;
      burst_q.delete();
      if (need == 2'd0) begin
        open_lead(b);
      end else if (b == 8'h00) begin
        flush_raw();
      end else begin
        cont_good = ((b & utf8d_pkg::ContMask) == utf8d_pkg::ContTag);
        // second-byte limits reject overlongs, surrogates and > U+10FFFF
        if (cont_good && taken == 2'd0) begin
          if (lead == utf8d_pkg::Lead3Lo && b < utf8d_pkg::E0Min) cont_good = 1'b0;
          if (lead == utf8d_pkg::LeadEd && b >= utf8d_pkg::EdLim) cont_good = 1'b0;
          if (lead == utf8d_pkg::Lead4Lo && b < utf8d_pkg::F0Min) cont_good = 1'b0;
          if (lead == utf8d_pkg::Lead4Hi && b >= utf8d_pkg::F4Lim) cont_good = 1'b0;
        end
        if (!cont_good) begin
          flush_raw();
          open_lead(b);
        end else if (int'(taken) + 1 < int'(need) && taken < 2'd2) begin
          cont[taken[0]] = b[5:0];
          taken = taken + 2'd1;
        end else begin
          case (need)
            2'd1:    cp = utf8d_pkg::CpW'({lead[4:0], b[5:0]});
            2'd2:    cp = utf8d_pkg::CpW'({lead[3:0], cont[0], b[5:0]});
            default: cp = {lead[2:0], cont[0], cont[1], b[5:0]};
          endcase
          clear_seq();
          burst_q.push_back(cp);
        end
      end
      if (burst_q.size() > 1) multi_bursts++;
      foreach (burst_q[i]) begin
        item.cp = burst_q[i];
        item.last = (i == burst_q.size() - 1);
        owed_q.push_back(item);
      end
    endfunction

    function void check_cp(logic [utf8d_pkg::CpW-1:0] cp, logic last);
      cp_item_t exp_item;
      if (owed_q.size() == 0) begin
        $display("%0t: result with nothing owed, actual cp %h last %b", $time, cp, last);
        errors++;
        return;
      end
      exp_item = owed_q.pop_front();
      cps_checked++;
      if (cp !== exp_item.cp) begin
        $display("%0t: code_point mismatch, expected %h actual %h", $time, exp_item.cp, cp);
        errors++;
      end
      if (last !== exp_item.last) begin
        $display("%0t: last_of_run mismatch, expected %b actual %b", $time,
                 exp_item.last, last);
        errors++;
      end
    endfunction
  endclass

  logic                      clk_i = 1'b0;
  logic                      rst_ni = 1'b0;
  logic                      in_valid_i = 1'b0;
  logic                      in_ready_o;
  logic [7:0]                data_byte_i = 8'h00;
  logic                      out_valid_o;
  logic                      out_ready_i = 1'b0;
  logic [utf8d_pkg::CpW-1:0] code_point_o;
  logic                      last_of_run_o;

  utf8_scoreboard sb;
  int             tx_idle_pct = 25;
  int             rx_idle_pct = 75;
  logic [7:0]     seq_q[$];

  utf8_decoder_raw_fallback i_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .data_byte_i  (data_byte_i),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .code_point_o (code_point_o),
    .last_of_run_o(last_of_run_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  always @(negedge clk_i) begin
    out_ready_i = ($urandom_range(0, 99) >= rx_idle_pct);
  end

  // both handshakes sampled with pre-edge values
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && in_ready_o) sb.note_byte(data_byte_i);
      if (out_valid_o && out_ready_i) sb.check_cp(code_point_o, last_of_run_o);
    end
  end

  function automatic int unsigned rand_scalar();
    int unsigned v;
    if ($urandom_range(0, 9) == 0) begin
      case ($urandom_range(0, 8))
        0:       v = 'h80;
        1:       v = 'h7ff;
        2:       v = 'h800;
        3:       v = 'hd7ff;
        4:       v = 'he000;
        5:       v = 'hffff;
        6:       v = 'h10000;
        7:       v = 'h10ffff;
        default: v = 'h7f;
      endcase
      return v;
    end
    case ($urandom_range(0, 3))
      0: v = $urandom_range(1, 'h7f);
      1: v = $urandom_range('h80, 'h7ff);
      2: begin
        v = $urandom_range('h800, 'hffff);
        if (v >= 'hd800 && v <= 'hdfff) v = v ^ 'h1000;
      end
      default: v = $urandom_range('h10000, 'h10ffff);
    endcase
    return v;
  endfunction

  function automatic void push_utf8(int unsigned cp);
    logic [20:0] v;
    v = cp[20:0];
    if (cp < 'h80) begin
      seq_q.push_back(v[7:0]);
    end else if (cp < 'h800) begin
      seq_q.push_back({3'b110, v[10:6]});
      seq_q.push_back({2'b10, v[5:0]});
    end else if (cp < 'h10000) begin
      seq_q.push_back({4'b1110, v[15:12]});
      seq_q.push_back({2'b10, v[11:6]});
      seq_q.push_back({2'b10, v[5:0]});
    end else begin
      seq_q.push_back({5'b11110, v[20:18]});
      seq_q.push_back({2'b10, v[17:12]});
      seq_q.push_back({2'b10, v[11:6]});
      seq_q.push_back({2'b10, v[5:0]});
    end
  endfunction

  // called at a falling edge, returns at the falling edge after the transaction
  task automatic send_byte(input logic [7:0] b);
    while ($urandom_range(0, 99) < tx_idle_pct) begin
      in_valid_i = 1'b0;
      @(negedge clk_i);
    end
    in_valid_i = 1'b1;
    data_byte_i = b;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  task automatic send_seq(inout int sent);
    foreach (seq_q[i]) send_byte(seq_q[i]);
    sent += seq_q.size();
    seq_q.delete();
  endtask

  task automatic drain_owed();
    in_valid_i = 1'b0;
    while (sb.owed_q.size() != 0) @(negedge clk_i);
  endtask

  task automatic send_random_unit(inout int sent);
    int          kind;
    int          cut;
    int unsigned cp;
    kind = $urandom_range(0, 99);
    if (kind < 55) begin
      push_utf8(rand_scalar());
    end else if (kind < 70) begin
      // truncated multi-byte sequence, broken by a non-continuation or end of string
      do cp = rand_scalar(); while (cp < 'h80);
      push_utf8(cp);
      cut = $urandom_range(1, seq_q.size() - 1);
      while (seq_q.size() > cut) void'(seq_q.pop_back());
      case ($urandom_range(0, 2))
        0:       seq_q.push_back(8'h00);
        1:       seq_q.push_back(8'($urandom_range(1, 'h7f)));
        default: seq_q.push_back(8'($urandom_range('hc0, 'hff)));
      endcase
    end else if (kind < 80) begin
      // second byte outside the lead's allowed window
      case ($urandom_range(0, 3))
        0: begin
          seq_q.push_back(utf8d_pkg::Lead3Lo);
          seq_q.push_back(8'($urandom_range('h80, 'h9f)));
        end
        1: begin
          seq_q.push_back(utf8d_pkg::LeadEd);
          seq_q.push_back(8'($urandom_range('ha0, 'hbf)));
        end
        2: begin
          seq_q.push_back(utf8d_pkg::Lead4Lo);
          seq_q.push_back(8'($urandom_range('h80, 'h8f)));
        end
        default: begin
          seq_q.push_back(utf8d_pkg::Lead4Hi);
          seq_q.push_back(8'($urandom_range('h90, 'hbf)));
        end
      endcase
      repeat ($urandom_range(0, 2)) seq_q.push_back(8'($urandom_range('h80, 'hbf)));
    end else if (kind < 88) begin
      seq_q.push_back(8'h00);
    end else begin
      seq_q.push_back(8'($urandom_range(0, 255)));
    end
    send_seq(sent);
  endtask

  initial begin
    #3_000_000;
    $display("CHECK FAILED");
    $finish;
  end

  initial begin
    int sent;
    sb = new();
    sent = 0;
    repeat (7) @(negedge clk_i);
    rst_ni = 1'b1;

    // corners: ASCII max, end of string, raw leads, stray continuation, range limits,
    // surrogate and above-range rejects, four-result break, flush on zero
    seq_q = '{8'h7f, 8'h00, 8'hc0, 8'hff, 8'h80,
              8'hdf, 8'hbf,
              8'he0, 8'ha0, 8'h80,
              8'hed, 8'ha0,
              8'hf4, 8'h8f, 8'hbf, 8'hbf,
              8'hf0, 8'h90, 8'h80, 8'h41,
              8'hf4, 8'h90,
              8'hc2, 8'h00};
    send_seq(sent);
    // hold the sender until every owed code point is out
    drain_owed();

    for (int phase = 0; phase < 3; phase++) begin
      case (phase)
        0: begin
          tx_idle_pct = 25;
          rx_idle_pct = 75;
        end
        1: begin
          tx_idle_pct = 75;
          rx_idle_pct = 25;
        end
        default: begin
          tx_idle_pct = 0;
          rx_idle_pct = 0;
        end
      endcase
      sent = 0;
      while (sent < 68) send_random_unit(sent);
      drain_owed();
    end
    repeat (10) @(negedge clk_i);

    $display("Fed %0d bytes: corner leads and limits, well-formed, truncated and", sb.bytes_seen);
    $display("out-of-range sequences, string ends and noise; %0d code points, %0d bursts",
             sb.cps_checked, sb.multi_bursts);
    if (sb.errors == 0 && sb.owed_q.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
